[rtl/core/pcr_pkg.sv]
// Shared types and constants for the palette colour replacement core.
// No dependencies; imported by the core and its port checker.
package pcr_pkg;

    localparam int PALETTE_ENTRIES = 32;

    localparam int RGB_W      = 24;
    localparam int CHAN_W     = 8;
    localparam int INDEX_W    = 5;

    // s_axis tdata: entry_index, red, green, blue, alpha, repl r/g/b (61 bits used)
    localparam int S_TDATA_W  = 64;
    // m_axis tdata: out_red, out_green, out_blue, out_alpha
    localparam int M_TDATA_W  = 32;

    localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [CHAN_W-1:0] ALPHA_CLEAR  = 8'h00;

    typedef enum logic {
        MODE_PIXEL = 1'b0,
        MODE_LOAD  = 1'b1
    } mode_t;

    typedef logic [RGB_W-1:0] rgb_t;

endpackage

[rtl/core/palette_color_replace_core.sv]
// Palette colour replacement core: register-held palette with parallel match.
// Depends on pcr_pkg.
//
// A pixel passes the stage 1 register and the result register to m_axis.
// Throughput: one item per cycle while m_axis is not stalled; loads and
// pixels may be mixed back to back. Load items produce no output and are
// written to the palette in stage 1. Reset (aresetn low, synchronous)
// clears the palette to black->black and empties both stages.
module palette_color_replace_core
    import pcr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [4:0] entry_index, [12:5] red, [20:13] green, [28:21] blue,
    // [36:29] alpha, [44:37] repl_red, [52:45] repl_green, [60:53] repl_blue
    input  logic [S_TDATA_W-1:0] s_tdata,
    // [0] mode
    input  logic [0:0]           s_tuser,

    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [7:0] out_red, [15:8] out_green, [23:16] out_blue, [31:24] out_alpha
    output logic [M_TDATA_W-1:0] m_tdata,
    // [0] replaced
    output logic [0:0]           m_tuser
);

    // stage 1 (input register)
    logic                s1_valid_reg, s1_valid_next;
    mode_t               s1_mode_reg;
    logic [INDEX_W-1:0]  s1_index_reg;
    rgb_t                s1_rgb_reg;
    logic [CHAN_W-1:0]   s1_alpha_reg;
    rgb_t                s1_repl_reg;

    // palette
    rgb_t                base_reg [PALETTE_ENTRIES];
    rgb_t                repl_reg [PALETTE_ENTRIES];

    // result register
    logic                m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                m_tuser_reg, m_tuser_next;

    logic                s_transfer;
    logic                out_free;
    logic                s1_is_pixel;
    logic                s1_is_load;
    logic [PALETTE_ENTRIES-1:0] hit;
    logic [PALETTE_ENTRIES-1:0] first_hit;
    rgb_t                sel_repl;
    logic                do_replace;

    assign out_free    = !m_tvalid_reg || m_tready;
    assign s1_is_pixel = s1_valid_reg && (s1_mode_reg == MODE_PIXEL);
    assign s1_is_load  = s1_valid_reg && (s1_mode_reg == MODE_LOAD);

    // a load always leaves stage 1; a pixel waits for the result register
    assign s_tready    = !s1_valid_reg || s1_is_load || out_free;
    assign s_transfer  = s_tvalid && s_tready;

    assign s1_valid_next = s_tready ? s_tvalid : s1_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_transfer) begin
            s1_mode_reg  <= mode_t'(s_tuser[0]);
            s1_index_reg <= s_tdata[4:0];
            s1_rgb_reg   <= {s_tdata[12:5], s_tdata[20:13], s_tdata[28:21]};
            s1_alpha_reg <= s_tdata[36:29];
            s1_repl_reg  <= {s_tdata[44:37], s_tdata[52:45], s_tdata[60:53]};
        end
    end

    // Palette write happens in stage 1 so a pixel right behind a load sees it.
    // The 5-bit index covers all 32 entries, so every load writes an entry.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PALETTE_ENTRIES; i++) begin
                base_reg[i] <= '0;
                repl_reg[i] <= '0;
            end
        end else if (s1_is_load) begin
            for (int i = 0; i < PALETTE_ENTRIES; i++) begin
                if (int'(s1_index_reg) == i) begin
                    base_reg[i] <= s1_rgb_reg;
                    repl_reg[i] <= s1_repl_reg;
                end
            end
        end
    end

    // parallel compare, lowest index wins via isolate-lowest-set-bit
    always_comb begin
        for (int i = 0; i < PALETTE_ENTRIES; i++) begin
            hit[i] = (base_reg[i] == s1_rgb_reg);
        end
    end

    assign first_hit = hit & (~hit + PALETTE_ENTRIES'(1));

    always_comb begin
        sel_repl = '0;
        for (int i = 0; i < PALETTE_ENTRIES; i++) begin
            sel_repl = sel_repl | (repl_reg[i] & {RGB_W{first_hit[i]}});
        end
    end

    assign do_replace = (|hit) && (s1_alpha_reg != ALPHA_CLEAR);

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (out_free) begin
            m_tvalid_next = s1_is_pixel;
            if (do_replace) begin
                m_tdata_next = {ALPHA_OPAQUE, sel_repl[7:0], sel_repl[15:8], sel_repl[23:16]};
                m_tuser_next = 1'b1;
            end else begin
                m_tdata_next = {s1_alpha_reg, s1_rgb_reg[7:0], s1_rgb_reg[15:8],
                                s1_rgb_reg[23:16]};
                m_tuser_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

endmodule

[rtl/core/pcr_checker.sv]
// Port-level checks for palette_color_replace_core, attached by bind.
// Depends on pcr_pkg.
module pcr_checker
    import pcr_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic [0:0]           s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [0:0]           m_tuser
);

    // stalled input transfer holds its payload
    a_s_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && !s_tready) |=> (s_tvalid && $stable(s_tdata) && $stable(s_tuser)))
        else $error("s_axis payload changed while stalled");

    // stalled result transfer holds its payload
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("m_axis payload changed while stalled");

    // nothing comes out on the first cycle after reset
    a_reset_empty: assert property (@(posedge aclk)
        (aresetn && !$past(aresetn)) |-> !m_tvalid)
        else $error("m_tvalid high straight after reset");

    // a substituted pixel is always opaque
    a_repl_opaque: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[31:24] == ALPHA_OPAQUE))
        else $error("replaced pixel without full alpha");

    // invisible pixels are never recoloured
    a_clear_bypass: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[31:24] == ALPHA_CLEAR)) |-> !m_tuser[0])
        else $error("alpha-zero pixel marked replaced");

endmodule

bind palette_color_replace_core pcr_checker u_pcr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
